@@ rtl/assert_macros.svh @@
// Assertion macros used by the core RTL of the low-flow fault qualifier.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/lffq_pkg.sv @@
// Package of the low-flow fault qualifier: payload and state types,
// register codes, window codes, reset values and counter helper functions.
// No dependencies.
`timescale 1ns / 1ps

package lffq_pkg;

	localparam int CntW = 16;
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	// Configuration register indexes.
	localparam logic [2:0] CFG_FIRST_THR   = 3'd0;
	localparam logic [2:0] CFG_PREHEAT_THR = 3'd1;
	localparam logic [2:0] CFG_FILL_TICKS  = 3'd2;
	localparam logic [2:0] CFG_PRE_TICKS   = 3'd3;
	localparam logic [2:0] CFG_EXT_TICKS   = 3'd4;
	localparam logic [2:0] CFG_CLEAR_TICKS = 3'd5;

	// Window codes.
	localparam logic [2:0] WIN_NONE      = 3'd0;
	localparam logic [2:0] WIN_FILL      = 3'd1;
	localparam logic [2:0] WIN_PREHEAT   = 3'd2;
	localparam logic [2:0] WIN_EXTRACT   = 3'd3;
	localparam logic [2:0] WIN_STERILIZE = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_FIRST_THR   = 8'd12;
	localparam logic [7:0]  RST_PREHEAT_THR = 8'd5;
	localparam logic [7:0]  RST_FILL_TICKS  = 8'd50;
	localparam logic [7:0]  RST_PRE_TICKS   = 8'd20;
	localparam logic [7:0]  RST_EXT_TICKS   = 8'd15;
	localparam logic [15:0] RST_CLEAR_TICKS = 16'd600;

	typedef struct packed {
		logic [2:0] window;
		logic       holding_block;
		logic       hot_selected;
		logic [7:0] flow_rate;
		logic       clear_request;
	} sample_t;

	typedef struct packed {
		logic block_error;
		logic soft_flow_error;
		logic stop_dispense;
		logic voice_request;
	} result_t;

	typedef struct packed {
		logic [7:0]  first_thr;
		logic [7:0]  preheat_thr;
		logic [7:0]  fill_ticks;
		logic [7:0]  pre_ticks;
		logic [7:0]  ext_ticks;
		logic [15:0] clear_ticks;
	} cfg_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] thr;
		logic [7:0] tim;
	} win_t;

	typedef struct packed {
		logic [CntW-1:0] low_cnt;
		logic [CntW-1:0] age_cnt;
		logic [CntW-1:0] rec_cnt;
		logic            latch;
		logic            soft_err;
	} state_t;

	function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
		return (v == CntMax) ? v : v + {{(CntW-1){1'b0}}, 1'b1};
	endfunction

	// One recovery step: advance the count and clear the soft error on time.
	function automatic state_t rec_step(input state_t s, input logic [7:0] tim);
		state_t r;
		r = s;
		r.rec_cnt = sat_inc(s.rec_cnt);
		if (r.rec_cnt >= {{(CntW-8){1'b0}}, tim}) begin
			r.soft_err = 1'b0;
			r.rec_cnt = '0;
		end
		return r;
	endfunction

endpackage

@@ rtl/lffq_window_decode.sv @@
// Window decoder: picks the check enable, flow threshold and qualification
// time for one item. Depends on lffq_pkg.
`timescale 1ns / 1ps

module lffq_window_decode (
	input  lffq_pkg::sample_t sample,
	input  lffq_pkg::cfg_t    cfg,
	output lffq_pkg::win_t    win
);

	always_comb begin
		win = '0;
		case (sample.window)
			lffq_pkg::WIN_FILL: begin
				win.enable = 1'b1;
				win.thr    = cfg.first_thr;
				win.tim    = cfg.fill_ticks;
			end
			lffq_pkg::WIN_PREHEAT: begin
				win.enable = !sample.holding_block;
				win.thr    = cfg.preheat_thr;
				win.tim    = cfg.pre_ticks;
			end
			lffq_pkg::WIN_EXTRACT: begin
				win.enable = 1'b1;
				win.thr    = cfg.first_thr;
				win.tim    = cfg.ext_ticks;
			end
			lffq_pkg::WIN_STERILIZE: begin
				win.enable = 1'b1;
				win.thr    = cfg.preheat_thr;
				win.tim    = cfg.pre_ticks;
			end
			default: begin
				// No window, or an unused code: threshold and time stay zero.
				win = '0;
			end
		endcase
	end

endmodule

@@ rtl/lffq_update.sv @@
// Next-state logic of the qualifier counters and flags for one item.
// Depends on lffq_pkg.
`timescale 1ns / 1ps

module lffq_update (
	input  lffq_pkg::sample_t sample,
	input  lffq_pkg::win_t    win,
	input  logic [15:0]       clear_ticks,
	input  lffq_pkg::state_t  cur,
	output lffq_pkg::state_t  nxt,
	output lffq_pkg::result_t result
);

	always_comb begin
		lffq_pkg::state_t s;
		logic             low;
		logic             rec_ok;
		logic             fault;
		logic [15:0]      inc;

		s      = cur;
		fault  = 1'b0;
		inc    = '0;
		low    = sample.flow_rate <= win.thr;
		rec_ok = !low && sample.hot_selected;

		// Qualification phase.
		if (win.enable && !cur.latch) begin
			if (low) begin
				inc = lffq_pkg::sat_inc(cur.low_cnt);
				if (inc >= {8'd0, win.tim}) begin
					s.latch    = 1'b1;
					s.soft_err = 1'b1;
					fault      = 1'b1;
					s.low_cnt  = '0;
				end else begin
					s.low_cnt = inc;
				end
			end else begin
				s.low_cnt = '0;
				s = lffq_pkg::rec_step(s, win.tim);
			end
		end else begin
			s.low_cnt = '0;
			if (win.enable && rec_ok) begin
				s = lffq_pkg::rec_step(s, win.tim);
			end
		end

		// Ageing phase: a clear request preloads the age so the latch drops now.
		if (sample.clear_request) begin
			s.age_cnt = clear_ticks;
		end
		if (s.latch) begin
			inc = lffq_pkg::sat_inc(s.age_cnt);
			if (inc >= clear_ticks) begin
				s.latch   = 1'b0;
				s.age_cnt = '0;
			end else begin
				s.age_cnt = inc;
			end
			// The recovery counter may step a second time within the same item.
			if (rec_ok) begin
				s = lffq_pkg::rec_step(s, win.tim);
			end
		end else begin
			s.age_cnt = '0;
		end

		nxt                    = s;
		result.block_error     = s.latch;
		result.soft_flow_error = s.soft_err;
		result.stop_dispense   = fault;
		result.voice_request   = fault;
	end

endmodule

@@ rtl/low_flow_fault_qualifier_core.sv @@
// Low-flow fault qualifier: one item per clock while results are taken.
// An accepted item is loaded into the input register, and passes into the result
// register when that register is empty or its result is being taken.
// The qualifier state update from the input register is combinational.
// Reset clears counters and flags and loads the register defaults.
// Depends on lffq_pkg, lffq_window_decode, lffq_update, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module low_flow_fault_qualifier_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  lffq_pkg::sample_t sample,
	output logic              result_valid,
	input  logic              result_ready,
	output lffq_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	lffq_pkg::cfg_t    cfg_q;
	lffq_pkg::sample_t sample_s1;
	logic              valid_s1;
	lffq_pkg::state_t  state_q;
	lffq_pkg::state_t  state_nxt;
	lffq_pkg::win_t    win;
	lffq_pkg::result_t result_nxt;
	lffq_pkg::result_t result_q;
	logic              result_valid_q;
	logic              advance;

	assign cfg_ready    = 1'b1;
	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_thr   <= lffq_pkg::RST_FIRST_THR;
			cfg_q.preheat_thr <= lffq_pkg::RST_PREHEAT_THR;
			cfg_q.fill_ticks  <= lffq_pkg::RST_FILL_TICKS;
			cfg_q.pre_ticks   <= lffq_pkg::RST_PRE_TICKS;
			cfg_q.ext_ticks   <= lffq_pkg::RST_EXT_TICKS;
			cfg_q.clear_ticks <= lffq_pkg::RST_CLEAR_TICKS;
		end else if (cfg_valid) begin
			case (cfg_index)
				lffq_pkg::CFG_FIRST_THR:   cfg_q.first_thr   <= cfg_data[7:0];
				lffq_pkg::CFG_PREHEAT_THR: cfg_q.preheat_thr <= cfg_data[7:0];
				lffq_pkg::CFG_FILL_TICKS:  cfg_q.fill_ticks  <= cfg_data[7:0];
				lffq_pkg::CFG_PRE_TICKS:   cfg_q.pre_ticks   <= cfg_data[7:0];
				lffq_pkg::CFG_EXT_TICKS:   cfg_q.ext_ticks   <= cfg_data[7:0];
				lffq_pkg::CFG_CLEAR_TICKS: cfg_q.clear_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	lffq_window_decode u_decode (
		.sample (sample_s1),
		.cfg    (cfg_q),
		.win    (win)
	);

	lffq_update u_update (
		.sample      (sample_s1),
		.win         (win),
		.clear_ticks (cfg_q.clear_ticks),
		.cur         (state_q),
		.nxt         (state_nxt),
		.result      (result_nxt)
	);

	// Qualifier state moves only when an item passes into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	`ASSERT_SAME(a_ready_when_out_free, !result_valid_q, sample_ready)
	`ASSERT_SAME(a_fault_sets_soft, result_valid_q && result_q.stop_dispense, result_q.soft_flow_error)
	`ASSERT_SAME(a_latched_low_clear, state_q.latch, state_q.low_cnt == '0)
	`ASSERT_NEXT(a_idle_age_clear, advance && !state_nxt.latch, state_q.age_cnt == '0)

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of low_flow_fault_qualifier_core: directed and random ticks with
// random idling on both channels, checked against a cycle-free model of the qualifier.
// Depends on lffq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

	// Window codes that the decoder upstream never produces; the block treats them as none.
	localparam logic [2:0] WIN_RSVD5 = 3'd5;
	localparam logic [2:0] WIN_RSVD6 = 3'd6;
	localparam logic [2:0] WIN_RSVD7 = 3'd7;
	// Register indexes with no register behind them.
	localparam logic [2:0] CFG_RSVD6 = 3'd6;
	localparam logic [2:0] CFG_RSVD7 = 3'd7;
	localparam int STALL_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              sample_valid = 1'b0;
	logic              sample_ready;
	lffq_pkg::sample_t sample = '0;
	logic              result_valid;
	logic              result_ready = 1'b0;
	lffq_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [2:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	bit                idling = 1'b1;
	int                failures = 0;
	int                quiet_cycles = 0;
	lffq_pkg::result_t expected_flags[$];

	// Copy of the register file and the qualifier state.
	logic [7:0]  lim_fill_ext, lim_pre_ster, qual_fill, qual_pre, qual_ext;
	logic [15:0] clear_after;
	logic [15:0] dry_ticks, held_age, recov_ticks;
	logic        fault_held, soft_held;

	low_flow_fault_qualifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [7:0] flow_limit(input logic [2:0] w);
		case (w)
			lffq_pkg::WIN_FILL, lffq_pkg::WIN_EXTRACT: return lim_fill_ext;
			lffq_pkg::WIN_PREHEAT, lffq_pkg::WIN_STERILIZE: return lim_pre_ster;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [7:0] qual_time(input logic [2:0] w);
		case (w)
			lffq_pkg::WIN_FILL: return qual_fill;
			lffq_pkg::WIN_PREHEAT, lffq_pkg::WIN_STERILIZE: return qual_pre;
			lffq_pkg::WIN_EXTRACT: return qual_ext;
			default: return 8'd0;
		endcase
	endfunction

	function automatic void advance_recovery(input logic [7:0] qt);
		recov_ticks = bump(recov_ticks);
		if (recov_ticks >= {8'd0, qt}) begin
			soft_held = 1'b0;
			recov_ticks = '0;
		end
	endfunction

	// Advances the qualifier by one tick and returns the flags it reports.
	function automatic lffq_pkg::result_t qualify_tick(input lffq_pkg::sample_t s);
		lffq_pkg::result_t r;
		logic              armed, low, wet;
		logic [7:0]        lim, qt;
		lim = flow_limit(s.window);
		qt = qual_time(s.window);
		armed = (s.window == lffq_pkg::WIN_FILL) || (s.window == lffq_pkg::WIN_EXTRACT) ||
			(s.window == lffq_pkg::WIN_STERILIZE) ||
			(s.window == lffq_pkg::WIN_PREHEAT && !s.holding_block);
		low = (s.flow_rate <= lim);
		wet = !low && s.hot_selected;
		r = '0;
		if (armed && !fault_held) begin
			if (low) begin
				dry_ticks = bump(dry_ticks);
				if (dry_ticks >= {8'd0, qt}) begin
					fault_held = 1'b1;
					soft_held = 1'b1;
					r.stop_dispense = 1'b1;
					r.voice_request = 1'b1;
					dry_ticks = '0;
				end
			end else begin
				dry_ticks = '0;
				advance_recovery(qt);
			end
		end else begin
			dry_ticks = '0;
			if (armed && wet)
				advance_recovery(qt);
		end
		if (s.clear_request)
			held_age = clear_after;
		// The latched branch runs with the window's limits even when the check is off.
		if (fault_held) begin
			held_age = bump(held_age);
			if (held_age >= clear_after) begin
				fault_held = 1'b0;
				held_age = '0;
			end
			if (wet)
				advance_recovery(qt);
		end else begin
			held_age = '0;
		end
		r.block_error = fault_held;
		r.soft_flow_error = soft_held;
		return r;
	endfunction

	function automatic void check_flag(input string name, input logic want, input logic got);
		if (got !== want) begin
			$error("%s: expected %0b, got %0b", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		lffq_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_flags.size() == 0) begin
				$error("result item arrived with no sample outstanding");
				failures++;
			end else begin
				want = expected_flags.pop_front();
				check_flag("block_error", want.block_error, result.block_error);
				check_flag("soft_flow_error", want.soft_flow_error, result.soft_flow_error);
				check_flag("stop_dispense", want.stop_dispense, result.stop_dispense);
				check_flag("voice_request", want.voice_request, result.voice_request);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: while idling is set, a random stall before each item is taken.
	initial begin : drain_results
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idling ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// Valid is only lowered when a gap follows, so a back-to-back item keeps it high.
	task automatic send_tick(input lffq_pkg::sample_t s);
		int gap;
		gap = idling ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		expected_flags.push_back(qualify_tick(s));
	endtask

	task automatic tick(input logic [2:0] w, input logic hold, input logic hot,
			input logic [7:0] flow, input logic clr);
		lffq_pkg::sample_t s;
		s.window = w;
		s.holding_block = hold;
		s.hot_selected = hot;
		s.flow_rate = flow;
		s.clear_request = clr;
		send_tick(s);
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (expected_flags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			lffq_pkg::CFG_FIRST_THR: lim_fill_ext = val[7:0];
			lffq_pkg::CFG_PREHEAT_THR: lim_pre_ster = val[7:0];
			lffq_pkg::CFG_FILL_TICKS: qual_fill = val[7:0];
			lffq_pkg::CFG_PRE_TICKS: qual_pre = val[7:0];
			lffq_pkg::CFG_EXT_TICKS: qual_ext = val[7:0];
			lffq_pkg::CFG_CLEAR_TICKS: clear_after = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Writes every register; the unused upper byte of the 8-bit ones carries noise.
	task automatic set_limits(input logic [7:0] thr_a, input logic [7:0] thr_b,
			input logic [7:0] t_fill, input logic [7:0] t_pre, input logic [7:0] t_ext,
			input logic [15:0] t_clear);
		logic [31:0] pad_a, pad_b;
		pad_a = $urandom;
		pad_b = $urandom;
		wait_drained();
		write_reg(lffq_pkg::CFG_FIRST_THR, {pad_a[7:0], thr_a});
		write_reg(lffq_pkg::CFG_PREHEAT_THR, {pad_a[15:8], thr_b});
		write_reg(lffq_pkg::CFG_FILL_TICKS, {pad_a[23:16], t_fill});
		write_reg(lffq_pkg::CFG_PRE_TICKS, {pad_a[31:24], t_pre});
		write_reg(lffq_pkg::CFG_EXT_TICKS, {pad_b[7:0], t_ext});
		write_reg(lffq_pkg::CFG_CLEAR_TICKS, t_clear);
	endtask

	// Mostly a run of low flow, which may or may not reach the qualification time, then a
	// run of recovered flow, both inside one window; one episode in ten is a fully random tick.
	task automatic run_episodes(input int n_items);
		int          sent, len, i;
		logic [2:0]  w;
		logic [7:0]  lim, qt;
		logic [31:0] r;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				r = $urandom;
				send_tick(r[$bits(lffq_pkg::sample_t)-1:0]);
				sent++;
			end else begin
				w = 3'($urandom_range(1, 4));
				// Adding four maps the active windows onto none and the unused codes.
				if ($urandom_range(0, 7) == 0)
					w = w + 3'd4;
				lim = flow_limit(w);
				qt = qual_time(w);
				len = $urandom_range(0, qt + 2);
				for (i = 0; i < len; i++) begin
					tick(w, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, lim)), $urandom_range(0, 31) == 0);
					sent++;
				end
				len = $urandom_range(0, qt + 2);
				for (i = 0; i < len; i++) begin
					tick(w, $urandom_range(0, 7) == 0, $urandom_range(0, 5) != 0,
						(lim == 8'hFF) ? 8'hFF : 8'($urandom_range(lim + 1, 255)),
						$urandom_range(0, 31) == 0);
					sent++;
				end
			end
		end
	endtask

	task automatic test_reset_values();
		run_episodes(200);
	endtask

	task automatic test_directed_cases();
		set_limits(8'd100, 8'd0, 8'd0, 8'd1, 8'd2, 16'd3);
		write_reg(CFG_RSVD6, 16'hFFFF);
		write_reg(CFG_RSVD7, 16'hA5A5);
		tick(lffq_pkg::WIN_NONE, 1'b0, 1'b0, 8'd0, 1'b0);
		// Zero qualification time faults on the first low tick.
		tick(lffq_pkg::WIN_FILL, 1'b0, 1'b0, 8'd0, 1'b0);
		tick(lffq_pkg::WIN_FILL, 1'b0, 1'b1, 8'd255, 1'b0);
		tick(lffq_pkg::WIN_FILL, 1'b0, 1'b1, 8'd100, 1'b0);
		tick(WIN_RSVD5, 1'b0, 1'b1, 8'd255, 1'b0);
		tick(lffq_pkg::WIN_PREHEAT, 1'b1, 1'b0, 8'd0, 1'b0);
		tick(lffq_pkg::WIN_PREHEAT, 1'b0, 1'b0, 8'd0, 1'b0);
		tick(WIN_RSVD6, 1'b1, 1'b1, 8'd0, 1'b1);
		tick(lffq_pkg::WIN_EXTRACT, 1'b0, 1'b1, 8'd100, 1'b0);
		tick(lffq_pkg::WIN_EXTRACT, 1'b0, 1'b1, 8'd100, 1'b0);
		tick(lffq_pkg::WIN_EXTRACT, 1'b0, 1'b1, 8'd101, 1'b0);
		tick(lffq_pkg::WIN_EXTRACT, 1'b0, 1'b0, 8'd255, 1'b0);
		tick(lffq_pkg::WIN_STERILIZE, 1'b0, 1'b1, 8'd0, 1'b0);
		tick(lffq_pkg::WIN_STERILIZE, 1'b0, 1'b1, 8'd1, 1'b0);
		tick(WIN_RSVD7, 1'b0, 1'b1, 8'd255, 1'b1);
		tick(lffq_pkg::WIN_PREHEAT, 1'b1, 1'b1, 8'd255, 1'b1);
		tick(lffq_pkg::WIN_FILL, 1'b1, 1'b1, 8'd0, 1'b0);
		tick(lffq_pkg::WIN_PREHEAT, 1'b1, 1'b1, 8'd255, 1'b0);
		tick(lffq_pkg::WIN_NONE, 1'b1, 1'b1, 8'd255, 1'b1);
		tick(lffq_pkg::WIN_STERILIZE, 1'b1, 1'b0, 8'd255, 1'b1);
	endtask

	task automatic test_random_settings();
		int k;
		for (k = 0; k < 3; k++) begin
			set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
				8'($urandom_range(0, 12)), 16'($urandom_range(1, 40)));
			run_episodes(150);
		end
	endtask

	task automatic test_back_to_back();
		set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
			8'($urandom_range(0, 8)), 16'($urandom_range(1, 20)));
		idling = 1'b0;
		run_episodes(200);
		idling = 1'b1;
	endtask

	// The longest clear time lets a clear request drive the age counter into saturation.
	task automatic test_extreme_settings();
		set_limits(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		run_episodes(250);
		set_limits(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd1);
		run_episodes(100);
	endtask

	task automatic test_pause_mid_stream();
		set_limits(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 10)), 8'($urandom_range(0, 10)),
			8'($urandom_range(0, 10)), 16'($urandom_range(1, 30)));
		run_episodes(75);
		wait_drained();
		run_episodes(75);
	endtask

	initial begin
		lim_fill_ext = lffq_pkg::RST_FIRST_THR;
		lim_pre_ster = lffq_pkg::RST_PREHEAT_THR;
		qual_fill = lffq_pkg::RST_FILL_TICKS;
		qual_pre = lffq_pkg::RST_PRE_TICKS;
		qual_ext = lffq_pkg::RST_EXT_TICKS;
		clear_after = lffq_pkg::RST_CLEAR_TICKS;
		dry_ticks = '0;
		held_age = '0;
		recov_ticks = '0;
		fault_held = 1'b0;
		soft_held = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed_cases();
		test_random_settings();
		test_back_to_back();
		test_extreme_settings();
		test_pause_mid_stream();
		wait_drained();
		repeat (6) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lffq_pkg.sv
rtl/lffq_window_decode.sv
rtl/lffq_update.sv
rtl/low_flow_fault_qualifier_core.sv
sim/tb.sv
